/* hdl/refcounted_frame_bin_manager_core_macros.svh */
// Assertion macros used by the frame bin manager core RTL.
`ifndef REFCOUNTED_FRAME_BIN_MANAGER_CORE_MACROS_SVH
`define REFCOUNTED_FRAME_BIN_MANAGER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RFBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame bin manager check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RFBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame bin manager check failed");

`endif

/* hdl/rfbm_pkg.sv */
// Shared constants, codes and record types for the frame bin manager.
package rfbm_pkg;

  localparam int NUM_BINS   = 16;
  localparam int COUNT_BITS = 16;

  localparam int HANDLE_W = 4;
  localparam int ADDR_W   = 32;
  localparam int BYTES_W  = 24;
  localparam int ID_W     = 32;
  localparam int MASK_W   = 16;
  localparam int STATUS_W = 3;

  typedef logic [HANDLE_W-1:0]   handle_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [BYTES_W-1:0]    bytes_t;
  typedef logic [ID_W-1:0]       id_t;
  typedef logic [MASK_W-1:0]     mask_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_NEW_PIC    = 2'd0,
    OP_NEW_CLIENT = 2'd1,
    OP_RELEASE    = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NO_PIC  = 3'd2,
    ST_BAD_REL = 3'd3,
    ST_SAT     = 3'd4
  } status_e;

  // Frame data of the request being worked, broadcast to every cell
  typedef struct packed {
    addr_t  addr;
    bytes_t bytes;
    id_t    id;
  } frame_t;

  // Request record that walks the row of cells, one cell per cycle
  typedef struct packed {
    logic    live;
    logic    active;
    op_e     op;
    handle_t target;
    logic    found;
    status_e status;
    handle_t handle;
    addr_t   addr;
    bytes_t  bytes;
    id_t     id;
    mask_t   mask;
  } rec_t;

endpackage

/* hdl/rfbm_cell.sv */
// One frame bin: holds its state and updates the passing request record.
module rfbm_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rfbm_pkg::handle_t cell_idx_i,
  input  rfbm_pkg::frame_t  frame_i,
  input  rfbm_pkg::rec_t    rec_i,
  output rfbm_pkg::rec_t    rec_o
);
  import rfbm_pkg::*;

  logic   val_q, val_d;
  cnt_t   cnt_q, cnt_d;
  addr_t  addr_q;
  bytes_t bytes_q;
  id_t    id_q;
  rec_t   rec_q, rec_d;
  logic   wr;
  logic   hit;
  logic   reclaim;

  assign hit     = rec_i.live && rec_i.active && (rec_i.target == cell_idx_i);
  assign reclaim = val_q && (cnt_q == '0);

  // Act on the record when it reaches this bin
  always_comb begin
    rec_d = rec_i;
    val_d = val_q;
    cnt_d = cnt_q;
    wr    = 1'b0;
    if (rec_i.live && rec_i.active) begin
      case (rec_i.op)
        OP_NEW_PIC: begin
          // free an unread bin, then claim the first free one along the row
          if (reclaim) begin
            val_d = 1'b0;
            rec_d.mask[cell_idx_i] = 1'b1;
          end
          if (!rec_i.found && (!val_q || reclaim)) begin
            val_d        = 1'b1;
            cnt_d        = '0;
            wr           = 1'b1;
            rec_d.found  = 1'b1;
            rec_d.status = ST_OK;
            rec_d.handle = cell_idx_i;
            rec_d.addr   = frame_i.addr;
            rec_d.bytes  = frame_i.bytes;
            rec_d.id     = frame_i.id;
          end
        end
        OP_NEW_CLIENT: begin
          if (hit) begin
            if (!val_q) begin
              rec_d.status = ST_NO_PIC;
              rec_d.handle = '0;
            end else if (cnt_q == CNT_MAX) begin
              rec_d.status = ST_SAT;
            end else begin
              cnt_d        = cnt_q + cnt_t'(1);
              rec_d.status = ST_OK;
              rec_d.addr   = addr_q;
              rec_d.bytes  = bytes_q;
              rec_d.id     = id_q;
            end
          end
        end
        OP_RELEASE: begin
          if (hit && val_q && (cnt_q != '0)) begin
            cnt_d        = cnt_q - cnt_t'(1);
            rec_d.status = ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // Bin state and the record handed to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 1'b0;
      cnt_q <= '0;
      rec_q <= '0;
    end else begin
      val_q <= val_d;
      cnt_q <= cnt_d;
      rec_q <= rec_d;
    end
  end

  // Frame data, no reset
  always_ff @(posedge clk_i) begin
    if (wr) begin
      addr_q  <= frame_i.addr;
      bytes_q <= frame_i.bytes;
      id_q    <= frame_i.id;
    end
  end

  assign rec_o = rec_q;

endmodule

/* hdl/refcounted_frame_bin_manager_core.sv */
// The request record walks the row of bin cells one cell per cycle, and a new
// request is taken only after the record leaves the last cell and while no
// result waits in the skid entry.
// A finished result may wait in the output register while the next request runs.
// Reset clears bin valid bits, reader counts, newest bin and id counter at once.
module refcounted_frame_bin_manager_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  rfbm_pkg::addr_t              buffer_addr_i,
  input  rfbm_pkg::bytes_t             frame_bytes_i,
  input  rfbm_pkg::handle_t            release_handle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rfbm_pkg::STATUS_W-1:0] status_o,
  output rfbm_pkg::handle_t            bin_handle_o,
  output rfbm_pkg::addr_t              out_addr_o,
  output rfbm_pkg::bytes_t             out_bytes_o,
  output rfbm_pkg::id_t                out_id_o,
  output rfbm_pkg::mask_t              freed_mask_o
);
  import rfbm_pkg::*;

  `include "refcounted_frame_bin_manager_core_macros.svh"

  typedef struct packed {
    status_e status;
    handle_t handle;
    addr_t   addr;
    bytes_t  bytes;
    id_t     id;
    mask_t   mask;
  } res_t;

  logic          in_acc;
  logic          out_take;
  logic          busy_q;
  logic          have_pic_q;
  handle_t       newest_q;
  id_t           next_id_q;
  frame_t        frame_q;
  rec_t          inj_q, inj_d;
  rec_t          chain [NUM_BINS+1];
  rec_t          end_rec;
  logic          end_live;
  logic          pic_done;
  res_t          end_res;
  res_t          out_q, pend_q;
  logic          out_vld_q, pend_vld_q;
  logic [NUM_BINS:0] live_vec;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_take = out_vld_q && !out_stall_i;
  assign in_stall_o = busy_q || pend_vld_q;

  // Build the request record for the head of the row
  always_comb begin
    inj_d      = '0;
    inj_d.live = in_acc;
    inj_d.op   = op_e'(op_i);
    inj_d.status = ST_OK;
    case (op_e'(op_i))
      OP_NEW_PIC: begin
        inj_d.active = 1'b1;
        inj_d.status = ST_FULL;
      end
      OP_NEW_CLIENT: begin
        inj_d.status = ST_NO_PIC;
        if (have_pic_q) begin
          inj_d.active = 1'b1;
          inj_d.target = newest_q;
          inj_d.handle = newest_q;
        end
      end
      OP_RELEASE: begin
        inj_d.active = 1'b1;
        inj_d.target = release_handle_i;
        inj_d.handle = release_handle_i;
        inj_d.status = ST_BAD_REL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_q <= '0;
    end else begin
      inj_q <= inj_d;
    end
  end

  // Frame data of the accepted request, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frame_q.addr  <= buffer_addr_i;
      frame_q.bytes <= frame_bytes_i;
      frame_q.id    <= next_id_q;
    end
  end

  // Row of bin cells
  assign chain[0] = inj_q;
  for (genvar k = 0; k < NUM_BINS; k++) begin : g_cell
    rfbm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (handle_t'(k)),
      .frame_i    (frame_q),
      .rec_i      (chain[k]),
      .rec_o      (chain[k+1])
    );
  end

  always_comb begin
    for (int k = 0; k <= NUM_BINS; k++) begin
      live_vec[k] = chain[k].live;
    end
  end

  assign end_rec  = chain[NUM_BINS];
  assign end_live = end_rec.live;
  assign pic_done = end_live && (end_rec.op == OP_NEW_PIC) && end_rec.found;

  assign end_res.status = end_rec.status;
  assign end_res.handle = end_rec.handle;
  assign end_res.addr   = end_rec.addr;
  assign end_res.bytes  = end_rec.bytes;
  assign end_res.id     = end_rec.id;
  assign end_res.mask   = end_rec.mask;

  // Sequencing and newest-picture bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      have_pic_q <= 1'b0;
      newest_q   <= '0;
      next_id_q  <= '0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (end_live) begin
        busy_q <= 1'b0;
      end
      if (pic_done) begin
        have_pic_q <= 1'b1;
        newest_q   <= end_rec.handle;
        next_id_q  <= next_id_q + id_t'(1);
      end
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (out_take) begin
        out_vld_q  <= pend_vld_q || end_live;
        pend_vld_q <= 1'b0;
      end else if (end_live) begin
        out_vld_q  <= 1'b1;
        pend_vld_q <= out_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (pend_vld_q) begin
        out_q <= pend_q;
      end else if (end_live) begin
        out_q <= end_res;
      end
    end else if (end_live) begin
      if (out_vld_q) begin
        pend_q <= end_res;
      end else begin
        out_q <= end_res;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = out_q.status;
  assign bin_handle_o = out_q.handle;
  assign out_addr_o   = out_q.addr;
  assign out_bytes_o  = out_q.bytes;
  assign out_id_o     = out_q.id;
  assign freed_mask_o = out_q.mask;

  // Checks
  `RFBM_ASSERT_IMP(a_one_record, 1'b1, $countones(live_vec) <= 1)
  `RFBM_ASSERT_IMP(a_end_has_room, end_live, busy_q && !pend_vld_q)
  `RFBM_ASSERT_IMP(a_skid_behind_out, pend_vld_q, out_vld_q)
  `RFBM_ASSERT_NXT(a_accept_injects, in_acc, busy_q && inj_q.live)
  `RFBM_ASSERT_NXT(a_pic_recorded, pic_done, have_pic_q)

endmodule

/* tb/sv/tb_refcounted_frame_bin_manager_core.sv */
// Self-checking testbench for the reference-counted frame bin manager core.
`timescale 1ns / 100ps

module tb_refcounted_frame_bin_manager_core;
  import rfbm_pkg::*;

  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         DRAIN_CYCLES   = 2 * (NUM_BINS + 2);
  localparam int         RANDOM_ITEMS   = 470;
  localparam int         PHASE_ITEMS    = 40;
  localparam logic [1:0] OP_UNUSED      = 2'd3;

  // One expected result of the pool
  typedef struct {
    status_e status;
    handle_t handle;
    addr_t   addr;
    bytes_t  nbytes;
    id_t     id;
    mask_t   mask;
  } bin_result_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic [1:0]          op_i             = OP_NEW_PIC;
  addr_t               buffer_addr_i    = '0;
  bytes_t              frame_bytes_i    = '0;
  handle_t             release_handle_i = '0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic [STATUS_W-1:0] status_o;
  handle_t             bin_handle_o;
  addr_t               out_addr_o;
  bytes_t              out_bytes_o;
  id_t                 out_id_o;
  mask_t               freed_mask_o;

  // Shadow copy of the bin table
  bit      slot_used    [NUM_BINS];
  cnt_t    slot_readers [NUM_BINS] = '{default: '0};
  addr_t   slot_addr    [NUM_BINS];
  bytes_t  slot_bytes   [NUM_BINS];
  id_t     slot_id      [NUM_BINS];
  handle_t newest_slot  = '0;
  bit      picture_seen = 1'b0;
  id_t     id_counter   = '0;

  bin_result_t pending_results[$];
  int          failures  = 0;
  bit          idling_on = 1'b1;

  refcounted_frame_bin_manager_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .buffer_addr_i    (buffer_addr_i),
    .frame_bytes_i    (frame_bytes_i),
    .release_handle_i (release_handle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .bin_handle_o     (bin_handle_o),
    .out_addr_o       (out_addr_o),
    .out_bytes_o      (out_bytes_o),
    .out_id_o         (out_id_o),
    .freed_mask_o     (freed_mask_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Applies one request to the shadow table and returns its result
  function automatic bin_result_t predict_pool_op(logic [1:0] op, addr_t addr, bytes_t nbytes,
                                                  handle_t h);
    bin_result_t res;
    int          free_slot;
    res = '{status: ST_OK, handle: '0, addr: '0, nbytes: '0, id: '0, mask: '0};
    free_slot = -1;
    case (op)
      OP_NEW_PIC: begin
        // reclaim every unread bin, then take the lowest free one
        for (int i = 0; i < NUM_BINS; i++) begin
          if (slot_used[i] && slot_readers[i] == '0) begin
            slot_used[i] = 1'b0;
            res.mask[i]  = 1'b1;
          end
        end
        for (int i = NUM_BINS - 1; i >= 0; i--) begin
          if (!slot_used[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          res.status = ST_FULL;
          res.mask   = '0;
        end else begin
          slot_used[free_slot]    = 1'b1;
          slot_readers[free_slot] = '0;
          slot_addr[free_slot]    = addr;
          slot_bytes[free_slot]   = nbytes;
          slot_id[free_slot]      = id_counter;
          id_counter              = id_counter + 1'b1;
          newest_slot             = handle_t'(free_slot);
          picture_seen            = 1'b1;
          res.handle              = handle_t'(free_slot);
          res.addr                = addr;
          res.nbytes              = nbytes;
          res.id                  = slot_id[free_slot];
        end
      end
      OP_NEW_CLIENT: begin
        if (!picture_seen || !slot_used[newest_slot]) begin
          res.status = ST_NO_PIC;
        end else begin
          res.handle = newest_slot;
          if (slot_readers[newest_slot] == CNT_MAX) begin
            res.status = ST_SAT;
          end else begin
            slot_readers[newest_slot] = slot_readers[newest_slot] + 1'b1;
            res.addr   = slot_addr[newest_slot];
            res.nbytes = slot_bytes[newest_slot];
            res.id     = slot_id[newest_slot];
          end
        end
      end
      OP_RELEASE: begin
        res.handle = h;
        if (int'(h) >= NUM_BINS || !slot_used[h] || slot_readers[h] == '0) begin
          res.status = ST_BAD_REL;
        end else begin
          slot_readers[h] = slot_readers[h] - 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic int stall_free_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(60, 200);
    return $urandom_range(1, 8);
  endfunction

  // A bin that currently has readers, or any handle when none has
  function automatic handle_t held_slot();
    handle_t held[$];
    for (int i = 0; i < NUM_BINS; i++) begin
      if (slot_used[i] && slot_readers[i] != '0) held.push_back(handle_t'(i));
    end
    if (held.size() == 0) return handle_t'($urandom);
    return held[$urandom_range(0, held.size() - 1)];
  endfunction

  // Sends one request; valid stays high when the next one follows at once
  task automatic send_request(logic [1:0] op, addr_t addr, bytes_t nbytes, handle_t h);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    buffer_addr_i    <= addr;
    frame_bytes_i    <= nbytes;
    release_handle_i <= h;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_pool_op(op, addr, nbytes, h));
  endtask

  task automatic send_picture(addr_t addr, bytes_t nbytes);
    send_request(OP_NEW_PIC, addr, nbytes, handle_t'($urandom));
  endtask

  task automatic send_client();
    send_request(OP_NEW_CLIENT, $urandom, bytes_t'($urandom), handle_t'($urandom));
  endtask

  task automatic send_release(handle_t h);
    send_request(OP_RELEASE, $urandom, bytes_t'($urandom), h);
  endtask

  // Requests against an empty pool
  task automatic test_empty_pool();
    send_client();
    send_release('0);
    send_release(handle_t'(NUM_BINS - 1));
    send_request(OP_UNUSED, '1, '1, '1);
  endtask

  // Field extremes, reclaim of unread bins and release errors
  task automatic test_reclaim_and_release();
    send_picture('0, '0);
    send_picture('1, '1);                       // bin 0 unread: reclaimed and reused
    send_client();
    send_picture(32'hA5A5_A5A5, 24'h5A_5A5A);
    send_picture(32'h5A5A_5A5A, 24'hA5_A5A5);   // bin 1 reclaimed
    send_client();
    send_client();
    repeat (3) send_release(handle_t'(1));      // third one finds a zero count
    send_release(handle_t'(NUM_BINS - 1));      // bin never filled
    send_release('0);
    send_picture(32'h8000_0001, 24'h80_0001);   // bins 0 and 1 freed together
    send_request(OP_UNUSED, '0, '0, '0);
  endtask

  // Fill every bin with a held picture, then overflow
  task automatic test_table_full();
    handle_t h;
    repeat (NUM_BINS) begin
      send_picture($urandom, bytes_t'($urandom));
      repeat ($urandom_range(1, 2)) send_client();
    end
    repeat (2) send_picture($urandom, bytes_t'($urandom));
    send_client();
    // empty one bin so that the next picture lands there
    h = handle_t'($urandom_range(0, NUM_BINS - 1));
    while (slot_readers[h] != '0) send_release(h);
    send_picture($urandom, bytes_t'($urandom));
  endtask

  // Phases that either fill the table or drain it, with some noise
  task automatic test_random_traffic();
    int pic_w;
    int client_w;
    int pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        idling_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 1) == 1) begin
          pic_w    = 30;
          client_w = 80;
        end else begin
          pic_w    = 20;
          client_w = 40;
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) send_request(OP_UNUSED, $urandom, bytes_t'($urandom), handle_t'($urandom));
      else if (pick < pic_w) send_picture($urandom, bytes_t'($urandom));
      else if (pick < client_w) send_client();
      else if (pick < 95) send_release(held_slot());
      else send_release(handle_t'($urandom));
    end
    idling_on = 1'b1;
  endtask

  // Clients and releases on the newest bin, back to back
  task automatic test_back_to_back();
    idling_on = 1'b0;
    send_picture($urandom, bytes_t'($urandom));
    repeat (6) send_client();
    repeat (2) send_release(newest_slot);
    send_client();
    idling_on = 1'b1;
    send_release(newest_slot);
    send_client();
  endtask

  // Reset, stimulus, final drain and verdict
  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_pool();
    test_reclaim_and_release();
    test_table_full();
    test_random_traffic();
    test_back_to_back();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Receiver stalls: while idling is on, free stretches alternate with stalls of random length
  initial begin : receiver_stall
    @(posedge rst_ni);
    forever begin
      repeat (idling_on ? stall_free_len() : 1) @(posedge clk_i);
      if (idling_on) begin
        out_stall_i <= 1'b1;
        repeat (1 + idle_len()) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      failures++;
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    bin_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result accepted with no request outstanding");
        failures++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status", exp_res.status, status_o);
        check_field("bin_handle", exp_res.handle, bin_handle_o);
        check_field("out_addr", exp_res.addr, out_addr_o);
        check_field("out_bytes", exp_res.nbytes, out_bytes_o);
        check_field("out_id", exp_res.id, out_id_o);
        check_field("freed_mask", exp_res.mask, freed_mask_o);
      end
    end
  end

  // Ends the run when neither side has moved for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $error("no request or result accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/rfbm_pkg.sv
hdl/rfbm_cell.sv
hdl/refcounted_frame_bin_manager_core.sv
tb/sv/tb_refcounted_frame_bin_manager_core.sv
